// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, clocked on clk with reset rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define HHAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define HHAR_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HHAR_ASSERT(lbl, prop, msg)
`define HHAR_ASSERT_ALL(lbl, prop, msg)

`endif

`endif

// ===== design/hhar_pkg.sv =====
// ----------------------------------------------------------------------------
// hhar_pkg
// types, codes and constants of the hub/authority ranking engine
// ----------------------------------------------------------------------------
`default_nettype none

package hhar_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int MAX_EDGES_DEF = 8192;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_RUN   = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_BAD_NODE = 2'd2;

  localparam logic [1:0] CFG_NODES      = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD  = 2'd1;
  localparam logic [1:0] CFG_ITER_LIMIT = 2'd2;

  localparam logic [10:0] NODES_RST      = 11'd1;
  localparam logic [31:0] THRESHOLD_RST  = 32'd21474836;
  localparam logic [15:0] ITER_LIMIT_RST = 16'd300;

  localparam logic [63:0] ONE_Q32     = 64'h0000_0001_0000_0000;
  localparam logic [31:0] SCORE_MAX   = 32'hFFFF_FFFF;
  localparam logic [47:0] ACC_MAX     = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] FLUSH_LIMIT = 32'd512;
  localparam int          DIV_STEPS   = 32;

  typedef struct packed {
    logic [1:0] req_type;
    logic [9:0] src_node;
    logic [9:0] dst_node;
    logic [9:0] query_node;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] rank_score;
    logic [15:0] iterations_run;
    logic        converged;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== design/hits_hub_authority_rank.sv =====
// ----------------------------------------------------------------------------
// hits_hub_authority_rank
// edge store and hub/authority ranking sequencer around a shared divider
// ----------------------------------------------------------------------------
// A run seeds the scores, then per iteration clears the accumulators, walks
// every stored edge (skipping one whose node lies past the node count),
// totals the vectors and normalizes each node, where two quotients from the
// single shared divider set the pace. These node loops run over the clamped
// node count. No request is taken while a request is in progress; the
// result register lets the next request in while a result waits.
`default_nettype none
`include "assert_macros.svh"

module hits_hub_authority_rank
  import hhar_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int NAW = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW = $clog2(MAX_EDGES + 1);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_RD     = 5'd1;
  localparam logic [4:0] ST_FIN    = 5'd2;
  localparam logic [4:0] ST_I_DIV  = 5'd3;
  localparam logic [4:0] ST_I_WAIT = 5'd4;
  localparam logic [4:0] ST_I_WR   = 5'd5;
  localparam logic [4:0] ST_CHK    = 5'd6;
  localparam logic [4:0] ST_CLR    = 5'd7;
  localparam logic [4:0] ST_E_RD   = 5'd8;
  localparam logic [4:0] ST_E_CHK  = 5'd9;
  localparam logic [4:0] ST_E_UPD  = 5'd10;
  localparam logic [4:0] ST_S_RD   = 5'd11;
  localparam logic [4:0] ST_S_ACC  = 5'd12;
  localparam logic [4:0] ST_D_RD   = 5'd13;
  localparam logic [4:0] ST_D_A    = 5'd14;
  localparam logic [4:0] ST_D_AW   = 5'd15;
  localparam logic [4:0] ST_D_H    = 5'd16;
  localparam logic [4:0] ST_D_HW   = 5'd17;
  localparam logic [4:0] ST_D_WR   = 5'd18;

  function automatic logic [47:0] acc_add(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + 49'(b);
    return s[48] ? ACC_MAX : s[47:0];
  endfunction

  function automatic logic [63:0] tot_add(input logic [63:0] a, input logic [47:0] b);
    logic [64:0] s;
    s = {1'b0, a} + 65'(b);
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  function automatic logic [63:0] tot_floor(input logic [63:0] a);
    return (a < ONE_Q32) ? ONE_Q32 : a;
  endfunction

  function automatic logic [31:0] flush(input logic [31:0] a);
    return (a < FLUSH_LIMIT) ? 32'd0 : a;
  endfunction

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // configuration
  logic [10:0] nodes_cfg_r;
  logic [31:0] thr_r;
  logic [15:0] limit_r;

  // control
  logic [4:0]     state_r, state_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic [ETW-1:0] eidx_r, eidx_nxt;
  logic [ETW-1:0] edge_total_r, edge_total_nxt;
  logic [NAW-1:0] s_r, s_nxt;
  logic [NAW-1:0] t_r, t_nxt;
  logic [31:0]    init_r, init_nxt;
  logic [31:0]    na_r, na_nxt;
  logic [15:0]    iter_r, iter_nxt;
  logic [63:0]    delta_r, delta_nxt;
  logic [63:0]    atot_r, atot_nxt;
  logic [63:0]    htot_r, htot_nxt;
  logic [1:0]     status_r, status_nxt;
  logic [31:0]    score_r, score_nxt;
  logic [15:0]    iter_count_r, iter_count_nxt;
  logic           conv_r, conv_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_t           out_data_r, out_data_nxt;

  // memories
  logic [9:0]  esrc_mem_r [MAX_EDGES];
  logic [9:0]  edst_mem_r [MAX_EDGES];
  logic [31:0] auth_mem_r [MAX_NODES];
  logic [31:0] hub_mem_r  [MAX_NODES];
  logic [47:0] aacc_mem_r [MAX_NODES];
  logic [47:0] hacc_mem_r [MAX_NODES];
  logic [9:0]  esrc_q_r, edst_q_r;
  logic [31:0] auth_q_r, hub_q_r;
  logic [47:0] aacc_q_r, hacc_q_r;

  logic           edge_we;
  logic           score_we, acc_we;
  logic [NAW-1:0] auth_wa, hub_wa, aacc_wa, hacc_wa;
  logic [31:0]    auth_wd, hub_wd;
  logic [47:0]    aacc_wd, hacc_wd;
  logic [NAW-1:0] auth_ra, hub_ra, aacc_ra, hacc_ra;

  logic [31:0]   nc_ext;
  logic [CW-1:0] n_act;
  logic          in_acc;
  logic          slot_free;
  logic          edge_ok;
  logic          last_node;
  logic          last_edge;
  logic [47:0]   a_sel, h_sel;
  logic [31:0]   dh_a, dh_h;

  div_req_t div_req;
  div_rsp_t div_rsp;

  hhar_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign nc_ext = 32'(nodes_cfg_r);
  assign n_act  = (nc_ext == 32'd0) ? CW'(1) :
                  (nc_ext > 32'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(nc_ext);

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign edge_ok   = (32'(esrc_q_r) < 32'(n_r)) && (32'(edst_q_r) < 32'(n_r));
  assign last_node = (idx_r == n_r - CW'(1));
  assign last_edge = (eidx_r + ETW'(1) == edge_total_r);

  assign a_sel = (aacc_q_r == 48'd0) ? 48'(auth_q_r) : aacc_q_r;
  assign h_sel = (hacc_q_r == 48'd0) ? 48'(hub_q_r) : hacc_q_r;
  assign dh_a  = abs_diff(auth_q_r, na_r);
  assign dh_h  = abs_diff(hub_q_r, div_rsp.quot);

  // node memory read addresses
  always_comb begin
    auth_ra = idx_r[NAW-1:0];
    hub_ra  = idx_r[NAW-1:0];
    aacc_ra = idx_r[NAW-1:0];
    hacc_ra = idx_r[NAW-1:0];
    if (state_r == ST_IDLE) begin
      auth_ra = NAW'(in_data.query_node);
    end else if (state_r == ST_E_CHK) begin
      auth_ra = NAW'(edst_q_r);
      aacc_ra = NAW'(edst_q_r);
      hub_ra  = NAW'(esrc_q_r);
      hacc_ra = NAW'(esrc_q_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    eidx_nxt       = eidx_r;
    edge_total_nxt = edge_total_r;
    s_nxt          = s_r;
    t_nxt          = t_r;
    init_nxt       = init_r;
    na_nxt         = na_r;
    iter_nxt       = iter_r;
    delta_nxt      = delta_r;
    atot_nxt       = atot_r;
    htot_nxt       = htot_r;
    status_nxt     = status_r;
    score_nxt      = score_r;
    iter_count_nxt = iter_count_r;
    conv_nxt       = conv_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    edge_we        = 1'b0;
    score_we       = 1'b0;
    acc_we         = 1'b0;
    auth_wa        = idx_r[NAW-1:0];
    hub_wa         = idx_r[NAW-1:0];
    aacc_wa        = idx_r[NAW-1:0];
    hacc_wa        = idx_r[NAW-1:0];
    auth_wd        = init_r;
    hub_wd         = init_r;
    aacc_wd        = '0;
    hacc_wd        = '0;
    div_req.start  = 1'b0;
    div_req.num    = {16'd0, aacc_q_r};
    div_req.den    = atot_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          status_nxt = STAT_OK;
          score_nxt  = '0;
          state_nxt  = ST_FIN;
          case (in_data.req_type)
            REQ_CLEAR: edge_total_nxt = '0;
            REQ_ADD: begin
              if ((32'(in_data.src_node) >= 32'(n_act)) ||
                  (32'(in_data.dst_node) >= 32'(n_act))) begin
                status_nxt = STAT_BAD_NODE;
              end else if (edge_total_r == ETW'(MAX_EDGES)) begin
                status_nxt = STAT_FULL;
              end else begin
                edge_we        = 1'b1;
                edge_total_nxt = edge_total_r + ETW'(1);
              end
            end
            REQ_RUN: begin
              n_nxt     = n_act;
              state_nxt = ST_I_DIV;
            end
            default: begin
              if (32'(in_data.query_node) >= 32'(n_act)) begin
                status_nxt = STAT_BAD_NODE;
              end else begin
                state_nxt = ST_RD;
              end
            end
          endcase
        end
      end
      ST_RD: begin
        score_nxt = auth_q_r;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.status         = status_r;
          out_data_nxt.rank_score     = score_r;
          out_data_nxt.iterations_run = iter_count_r;
          out_data_nxt.converged      = conv_r;
          state_nxt                   = ST_IDLE;
        end
      end
      ST_I_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = ONE_Q32;
        div_req.den   = {32'(n_r), 32'd0};
        state_nxt     = ST_I_WAIT;
      end
      ST_I_WAIT: begin
        if (div_rsp.done) begin
          init_nxt  = div_rsp.quot;
          idx_nxt   = '0;
          state_nxt = ST_I_WR;
        end
      end
      ST_I_WR: begin
        score_we = 1'b1;
        idx_nxt  = idx_r + CW'(1);
        if (last_node) begin
          iter_nxt  = '0;
          delta_nxt = 64'hFFFF_FFFF_FFFF_FFFF;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if ((iter_r < limit_r) && (delta_r > 64'(thr_r))) begin
          idx_nxt   = '0;
          state_nxt = ST_CLR;
        end else begin
          iter_count_nxt = iter_r;
          conv_nxt       = (delta_r <= 64'(thr_r));
          state_nxt      = ST_FIN;
        end
      end
      ST_CLR: begin
        acc_we  = 1'b1;
        idx_nxt = idx_r + CW'(1);
        if (last_node) begin
          eidx_nxt = '0;
          idx_nxt  = '0;
          atot_nxt = '0;
          htot_nxt = '0;
          state_nxt = (edge_total_r == '0) ? ST_S_RD : ST_E_RD;
        end
      end
      ST_E_RD: begin
        state_nxt = ST_E_CHK;
      end
      ST_E_CHK: begin
        s_nxt = NAW'(esrc_q_r);
        t_nxt = NAW'(edst_q_r);
        if (edge_ok) begin
          state_nxt = ST_E_UPD;
        end else begin
          eidx_nxt  = eidx_r + ETW'(1);
          state_nxt = last_edge ? ST_S_RD : ST_E_RD;
        end
      end
      ST_E_UPD: begin
        acc_we    = 1'b1;
        aacc_wa   = t_r;
        hacc_wa   = s_r;
        aacc_wd   = acc_add(aacc_q_r, hub_q_r);
        hacc_wd   = acc_add(hacc_q_r, auth_q_r);
        eidx_nxt  = eidx_r + ETW'(1);
        state_nxt = last_edge ? ST_S_RD : ST_E_RD;
      end
      ST_S_RD: begin
        state_nxt = ST_S_ACC;
      end
      ST_S_ACC: begin
        acc_we   = 1'b1;
        aacc_wd  = a_sel;
        hacc_wd  = h_sel;
        atot_nxt = tot_add(atot_r, a_sel);
        htot_nxt = tot_add(htot_r, h_sel);
        idx_nxt  = idx_r + CW'(1);
        state_nxt = ST_S_RD;
        if (last_node) begin
          atot_nxt  = tot_floor(tot_add(atot_r, a_sel));
          htot_nxt  = tot_floor(tot_add(htot_r, h_sel));
          idx_nxt   = '0;
          delta_nxt = '0;
          state_nxt = ST_D_RD;
        end
      end
      ST_D_RD: begin
        state_nxt = ST_D_A;
      end
      ST_D_A: begin
        div_req.start = 1'b1;
        state_nxt     = ST_D_AW;
      end
      ST_D_AW: begin
        if (div_rsp.done) begin
          na_nxt    = div_rsp.quot;
          state_nxt = ST_D_H;
        end
      end
      ST_D_H: begin
        div_req.start = 1'b1;
        div_req.num   = {16'd0, hacc_q_r};
        div_req.den   = htot_r;
        state_nxt     = ST_D_HW;
      end
      ST_D_HW: begin
        if (div_rsp.done) begin
          state_nxt = ST_D_WR;
        end
      end
      ST_D_WR: begin
        score_we  = 1'b1;
        auth_wd   = flush(na_r);
        hub_wd    = flush(div_rsp.quot);
        delta_nxt = delta_r + 64'(dh_a) + 64'(dh_h);
        idx_nxt   = idx_r + CW'(1);
        state_nxt = ST_D_RD;
        if (last_node) begin
          iter_nxt  = iter_r + 16'd1;
          state_nxt = ST_CHK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_cfg_r <= NODES_RST;
      thr_r       <= THRESHOLD_RST;
      limit_r     <= ITER_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NODES:      nodes_cfg_r <= cfg_data[10:0];
        CFG_THRESHOLD:  thr_r       <= cfg_data;
        CFG_ITER_LIMIT: limit_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      edge_total_r <= '0;
      iter_count_r <= '0;
      conv_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      edge_total_r <= edge_total_nxt;
      iter_count_r <= iter_count_nxt;
      conv_r       <= conv_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    eidx_r     <= eidx_nxt;
    s_r        <= s_nxt;
    t_r        <= t_nxt;
    init_r     <= init_nxt;
    na_r       <= na_nxt;
    iter_r     <= iter_nxt;
    delta_r    <= delta_nxt;
    atot_r     <= atot_nxt;
    htot_r     <= htot_nxt;
    status_r   <= status_nxt;
    score_r    <= score_nxt;
    out_data_r <= out_data_nxt;
  end

  // edge store
  always_ff @(posedge clk) begin
    if (edge_we) begin
      esrc_mem_r[edge_total_r[EAW-1:0]] <= in_data.src_node;
      edst_mem_r[edge_total_r[EAW-1:0]] <= in_data.dst_node;
    end
    esrc_q_r <= esrc_mem_r[eidx_r[EAW-1:0]];
    edst_q_r <= edst_mem_r[eidx_r[EAW-1:0]];
  end

  // score stores
  always_ff @(posedge clk) begin
    if (score_we) begin
      auth_mem_r[auth_wa] <= auth_wd;
      hub_mem_r[hub_wa]   <= hub_wd;
    end
    auth_q_r <= auth_mem_r[auth_ra];
    hub_q_r  <= hub_mem_r[hub_ra];
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (acc_we) begin
      aacc_mem_r[aacc_wa] <= aacc_wd;
      hacc_mem_r[hacc_wa] <= hacc_wd;
    end
    aacc_q_r <= aacc_mem_r[aacc_ra];
    hacc_q_r <= hacc_mem_r[hacc_ra];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `HHAR_ASSERT_ALL(a_rst_idle, !rst_n |=> (state_r == ST_IDLE && !out_valid_r), "reset not idle")
  `HHAR_ASSERT(a_edge_bound, 32'(edge_total_r) <= 32'(MAX_EDGES), "edge count overflow")
  `HHAR_ASSERT(a_div_free, div_req.start |-> !div_rsp.busy, "divider started while busy")
  `HHAR_ASSERT(a_node_idx, (state_r == ST_S_ACC || state_r == ST_D_WR) |-> (idx_r < n_r),
               "node index out of range")

endmodule

`default_nettype wire

// ===== design/hhar_div.sv =====
// ----------------------------------------------------------------------------
// hhar_div
// shared restoring fraction divider, floor(num * 2^32 / den), one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hhar_div
  import hhar_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] den_r, den_nxt;
  logic [31:0] q_r, q_nxt;
  logic [63:0] gap;

  assign gap = den_r - rem_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (req.start) begin
      if (req.num >= req.den) begin
        q_nxt    = SCORE_MAX;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        rem_nxt  = req.num;
        den_nxt  = req.den;
        q_nxt    = '0;
        cnt_nxt  = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (rem_r >= gap) begin
        rem_nxt = rem_r - gap;
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], 1'b0};
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

`default_nettype wire

// ===== bench/hits_hub_authority_rank_test.sv =====
// ----------------------------------------------------------------------------
// hits_hub_authority_rank_test
// self-checking bench for the hub/authority ranking engine: requests are
// predicted on acceptance by a scoreboard that keeps its own copy of the
// link store and the score vectors, results are checked in order under
// random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class rank_scoreboard;
  int unsigned node_cnt;
  int unsigned threshold;
  int unsigned iter_limit;
  bit [9:0]    link_src[hhar_pkg::MAX_EDGES_DEF];
  bit [9:0]    link_dst[hhar_pkg::MAX_EDGES_DEF];
  int unsigned link_cnt;
  bit [31:0]   auth[hhar_pkg::MAX_NODES_DEF];
  bit [31:0]   hub[hhar_pkg::MAX_NODES_DEF];
  bit          scored[hhar_pkg::MAX_NODES_DEF];
  bit [63:0]   acc_a[hhar_pkg::MAX_NODES_DEF];
  bit [63:0]   acc_h[hhar_pkg::MAX_NODES_DEF];
  bit [15:0]   iters;
  bit          conv;
  hhar_pkg::out_t pending[$];
  int          errors;
  int          requests;
  int          runs;
  int          results;

  function new();
    node_cnt   = hhar_pkg::NODES_RST;
    threshold  = hhar_pkg::THRESHOLD_RST;
    iter_limit = hhar_pkg::ITER_LIMIT_RST;
  endfunction

  function int unsigned live_nodes();
    if (node_cnt < 1) return 1;
    if (node_cnt > hhar_pkg::MAX_NODES_DEF) return hhar_pkg::MAX_NODES_DEF;
    return node_cnt;
  endfunction

  function void configure(logic [1:0] idx, logic [31:0] value);
    case (idx)
      hhar_pkg::CFG_NODES:      node_cnt = value[10:0];
      hhar_pkg::CFG_THRESHOLD:  threshold = value;
      hhar_pkg::CFG_ITER_LIMIT: iter_limit = value[15:0];
      default: ;
    endcase
  endfunction

  function bit [31:0] quotient(bit [63:0] num, bit [63:0] den);
    bit [127:0] wide;
    if (num >= den) return hhar_pkg::SCORE_MAX;
    wide = 128'(num);
    wide = (wide << 32) / den;
    return wide[31:0];
  endfunction

  function bit [63:0] sat48(bit [63:0] x);
    return (x > hhar_pkg::ACC_MAX) ? 64'(hhar_pkg::ACC_MAX) : x;
  endfunction

  function void run_ranking();
    int unsigned n, it, s, t;
    bit [63:0] seed, delta, tot_a, tot_h;
    bit [31:0] na, nh;
    n = live_nodes();
    seed = hhar_pkg::ONE_Q32 / n;
    if (seed > hhar_pkg::SCORE_MAX) seed = hhar_pkg::SCORE_MAX;
    for (int i = 0; i < n; i++) begin
      auth[i] = seed[31:0];
      hub[i] = seed[31:0];
      scored[i] = 1'b1;
    end
    delta = '1;
    it = 0;
    while (it < iter_limit && delta > threshold) begin
      for (int i = 0; i < n; i++) begin
        acc_a[i] = 0;
        acc_h[i] = 0;
      end
      for (int e = 0; e < link_cnt; e++) begin
        s = link_src[e];
        t = link_dst[e];
        if (s < n && t < n) begin
          acc_a[t] = sat48(acc_a[t] + hub[s]);
          acc_h[s] = sat48(acc_h[s] + auth[t]);
        end
      end
      tot_a = 0;
      tot_h = 0;
      for (int i = 0; i < n; i++) begin
        if (acc_a[i] == 0) acc_a[i] = auth[i];
        if (acc_h[i] == 0) acc_h[i] = hub[i];
        tot_a += acc_a[i];
        tot_h += acc_h[i];
      end
      if (tot_a < hhar_pkg::ONE_Q32) tot_a = hhar_pkg::ONE_Q32;
      if (tot_h < hhar_pkg::ONE_Q32) tot_h = hhar_pkg::ONE_Q32;
      delta = 0;
      for (int i = 0; i < n; i++) begin
        na = quotient(acc_a[i], tot_a);
        nh = quotient(acc_h[i], tot_h);
        delta += (auth[i] > na) ? 64'(auth[i] - na) : 64'(na - auth[i]);
        delta += (hub[i] > nh) ? 64'(hub[i] - nh) : 64'(nh - hub[i]);
        auth[i] = (na < hhar_pkg::FLUSH_LIMIT) ? 32'd0 : na;
        hub[i] = (nh < hhar_pkg::FLUSH_LIMIT) ? 32'd0 : nh;
      end
      it++;
    end
    iters = it[15:0];
    conv = (delta <= threshold);
    runs++;
  endfunction

  function void note_request(hhar_pkg::in_t r);
    hhar_pkg::out_t e;
    int unsigned n;
    n = live_nodes();
    e = '0;
    requests++;
    case (r.req_type)
      hhar_pkg::REQ_CLEAR: link_cnt = 0;
      hhar_pkg::REQ_ADD: begin
        if (r.src_node >= n || r.dst_node >= n) e.status = hhar_pkg::STAT_BAD_NODE;
        else if (link_cnt >= hhar_pkg::MAX_EDGES_DEF) e.status = hhar_pkg::STAT_FULL;
        else begin
          link_src[link_cnt] = r.src_node;
          link_dst[link_cnt] = r.dst_node;
          link_cnt++;
        end
      end
      hhar_pkg::REQ_RUN: run_ranking();
      default: begin
        if (r.query_node >= n) e.status = hhar_pkg::STAT_BAD_NODE;
        else e.rank_score = auth[r.query_node];
      end
    endcase
    e.iterations_run = iters;
    e.converged = conv;
    pending = {pending, e};
  endfunction

  function void check_result(hhar_pkg::out_t got);
    hhar_pkg::out_t want;
    results++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status || got.rank_score !== want.rank_score ||
        got.iterations_run !== want.iterations_run || got.converged !== want.converged) begin
      errors++;
      if (errors <= 10)
        $display("result %0d: expected status %0d score %h iters %0d conv %0d, got %0d %h %0d %0d",
                 results, want.status, want.rank_score, want.iterations_run, want.converged,
                 got.status, got.rank_score, got.iterations_run, got.converged);
    end
  endfunction
endclass

module hits_hub_authority_rank_test;
  import hhar_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  rank_scoreboard sb = new();
  int stall_mode = 0;
  int stall_left = 0;
  int cyc = 0;

  hits_hub_authority_rank i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    #200_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver stall pattern
  always @(negedge clk) begin
    cyc <= cyc + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(64, 512);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (cyc % 5 < 2);
    endcase
  end

  task automatic send(in_t r);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
  endtask

  task automatic hold_off(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    hold_off(0);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.configure(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup(logic [31:0] nodes, logic [31:0] thr, logic [31:0] lim);
    drain();
    write_reg(CFG_NODES, nodes);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_ITER_LIMIT, lim);
  endtask

  task automatic request(logic [1:0] kind, int src, int dst, int q);
    in_t r;
    r = in_t'($urandom);
    r.req_type = kind;
    r.src_node = 10'(src);
    r.dst_node = 10'(dst);
    r.query_node = 10'(q);
    send(r);
  endtask

  task automatic random_request();
    in_t r;
    int unsigned n, pick;
    n = sb.live_nodes();
    r = in_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 4) r.req_type = REQ_CLEAR;
    else if (pick < 62) begin
      r.req_type = REQ_ADD;
      if (pick >= 10) begin
        r.src_node = 10'($urandom_range(0, n - 1));
        r.dst_node = 10'($urandom_range(0, n - 1));
      end
    end else if (pick < 70) r.req_type = REQ_RUN;
    else begin
      r.req_type = REQ_READ;
      if (pick >= 76) r.query_node = 10'($urandom_range(0, n - 1));
      if (r.query_node < n && !sb.scored[r.query_node]) begin
        if (n < MAX_NODES_DEF) r.query_node = 10'($urandom_range(n, MAX_NODES_DEF - 1));
        else r.req_type = REQ_CLEAR;
      end
    end
    send(r);
  endtask

  initial begin
    int burst;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single node at reset settings, bad nodes before any run
    request(REQ_READ, 0, 0, 1023);
    request(REQ_ADD, 1023, 0, 0);
    request(REQ_ADD, 0, 1023, 0);
    request(REQ_ADD, 0, 0, 0);
    request(REQ_RUN, 0, 0, 0);
    request(REQ_READ, 0, 0, 0);
    request(REQ_CLEAR, 1023, 1023, 1023);

    // small graph with duplicates and a self loop, exact convergence
    setup(8, 0, 5);
    request(REQ_ADD, 0, 1, 0);
    request(REQ_ADD, 0, 1, 0);
    request(REQ_ADD, 1, 2, 0);
    request(REQ_ADD, 2, 2, 0);
    request(REQ_ADD, 7, 3, 0);
    request(REQ_ADD, 6, 5, 0);
    request(REQ_ADD, 8, 1, 0);
    request(REQ_RUN, 0, 0, 0);
    for (int q = 0; q < 9; q++) request(REQ_READ, 0, 0, q);

    // links past the node count stay stored but are skipped
    setup(4, 32'hFFFF_FFFF, 16);
    request(REQ_RUN, 0, 0, 0);
    request(REQ_READ, 0, 0, 1);
    drain();
    write_reg(CFG_ITER_LIMIT, 0);
    request(REQ_RUN, 0, 0, 0);
    request(REQ_READ, 0, 0, 3);

    // node count clamped low, biggest iteration limit
    setup(0, 32'hFFFF_FFFF, 16'hFFFF);
    request(REQ_RUN, 0, 0, 0);
    request(REQ_READ, 0, 0, 0);
    request(REQ_READ, 0, 0, 1);

    // node count clamped high, one iteration over all nodes
    setup(2047, 32'hFFFF_FFFF, 1);
    request(REQ_CLEAR, 0, 0, 0);
    request(REQ_ADD, 1023, 0, 0);
    request(REQ_ADD, 0, 1023, 0);
    request(REQ_ADD, 512, 1023, 0);
    request(REQ_RUN, 0, 0, 0);
    request(REQ_READ, 0, 0, 1023);
    request(REQ_READ, 0, 0, 512);

    // two nodes linked both ways, one iteration
    setup(2, 32'd21474836, 1);
    request(REQ_CLEAR, 0, 0, 0);
    request(REQ_ADD, 1, 0, 0);
    request(REQ_ADD, 0, 1, 0);
    request(REQ_ADD, 2, 0, 0);
    request(REQ_RUN, 0, 0, 0);
    request(REQ_READ, 0, 0, 1);
    request(REQ_CLEAR, 0, 0, 0);

    // random sections under varied settings
    for (int sec = 0; sec < 9; sec++) begin
      setup(($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12),
            ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h0200_0000),
            $urandom_range(1, 20));
      for (int k = 0; k < 40; k++) begin
        random_request();
        if (burst == 0) begin
          burst = $urandom_range(1, 12);
          if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 5));
        end else begin
          burst--;
        end
      end
    end

    drain();
    $display("%0d requests, %0d ranking runs, %0d results checked",
             sb.requests, sb.runs, sb.results);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
